/* design/crcsd_pkg.sv */
// Package for the serial CRC divider: transaction types, register indexes
// and reset values shared by the configuration block, the step logic and the top level.
// No dependencies.
package crcsd_pkg;

  localparam int MAX_DEGREE_DEF = 32;

  localparam int GEN_W    = 32;
  localparam int DEGREE_W = 6;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GENERATOR_LOW = 2'd0,
    REG_DEGREE        = 2'd1,
    REG_CHECK_MODE    = 2'd2
  } cfg_reg_t;

  localparam logic [GEN_W-1:0]    GEN_RESET    = 32'h04C1_1DB7;
  localparam logic [DEGREE_W-1:0] DEGREE_RESET = 6'd32;

  typedef struct packed {
    logic data_bit;
    logic last;
  } in_item_t;

  typedef struct packed {
    logic             quotient_bit;
    logic             frame_end;
    logic [GEN_W-1:0] remainder;
    logic             error;
  } out_item_t;

endpackage

/* design/crc_serial_divider_top.sv */
// Top level of the serial CRC divider: input register, division step,
// partial remainder and output register. Depends on crcsd_pkg, crcsd_cfg, crcsd_step.
//
// Usage: one message bit per input transaction, most significant first, with
// last marking the final bit of a frame. Every input transaction yields one
// result transaction carrying the quotient bit; on the last bit the result
// also carries the remainder and the error flag, and the partial remainder
// clears for the next frame.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) sets
// the generator, degree and mode; cfg_ready is always high, and writes are
// meant to happen while no transaction is in flight.
// A bit accepted into the input register passes through the division step
// into the output register, which drives out_valid. Throughput: one bit per
// cycle while out_stall is low; the shift-and-xor remainder feedback is combinational.
// When the receiver stalls, the output register holds its transaction; the
// input register keeps the next bit and in_stall rises only when both are full.
// Synchronous reset empties both registers, zeroes the partial remainder and
// restores the default generator (degree 32, encode mode).
module crc_serial_divider_top #(
  parameter int MAX_DEGREE = crcsd_pkg::MAX_DEGREE_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  crcsd_pkg::in_item_t             in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output crcsd_pkg::out_item_t            out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [crcsd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [crcsd_pkg::GEN_W-1:0]     cfg_data
);
  import crcsd_pkg::*;

  localparam int EDW = $clog2(MAX_DEGREE + 1);

  logic [GEN_W-1:0]      generator_low;
  logic [EDW-1:0]        eff_degree;
  logic                  check_mode;

  logic                  in_vld_r;
  in_item_t              in_r;
  logic                  out_vld_r;
  out_item_t             out_r;
  logic [MAX_DEGREE-1:0] rem_r;
  logic [MAX_DEGREE-1:0] rem_nxt;
  out_item_t             result;
  logic                  out_free;
  logic                  advance;
  logic                  in_free;

  assign cfg_ready = 1'b1;

  crcsd_cfg #(
    .MAX_DEGREE (MAX_DEGREE),
    .EDW        (EDW)
  ) u_cfg (
    .clk           (clk),
    .rst_n         (rst_n),
    .wr_en         (cfg_valid & cfg_ready),
    .wr_index      (cfg_index),
    .wr_data       (cfg_data),
    .generator_low (generator_low),
    .eff_degree    (eff_degree),
    .check_mode    (check_mode)
  );

  crcsd_step #(
    .MAX_DEGREE (MAX_DEGREE),
    .EDW        (EDW)
  ) u_step (
    .rem           (rem_r),
    .item          (in_r),
    .generator_low (generator_low),
    .eff_degree    (eff_degree),
    .check_mode    (check_mode),
    .rem_nxt       (rem_nxt),
    .result        (result)
  );

  assign out_free = !out_vld_r || !out_stall;
  assign advance  = in_vld_r && out_free;
  assign in_free  = !in_vld_r || out_free;
  assign in_stall = !in_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      rem_r     <= '0;
    end else begin
      if (in_free) begin
        in_vld_r <= in_valid;
      end
      if (out_free) begin
        out_vld_r <= in_vld_r;
      end
      // The partial remainder moves only when a bit passes to the output.
      if (advance) begin
        rem_r <= rem_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_free && in_valid) begin
      in_r <= in_data;
    end
    if (advance) begin
      out_r <= result;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule

/* design/crcsd_cfg.sv */
// Configuration registers of the serial CRC divider and the clamped
// effective degree derived from them. Depends on crcsd_pkg.
module crcsd_cfg #(
  parameter int MAX_DEGREE = crcsd_pkg::MAX_DEGREE_DEF,
  parameter int EDW        = $clog2(MAX_DEGREE + 1)
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           wr_en,
  input  logic [crcsd_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [crcsd_pkg::GEN_W-1:0]    wr_data,
  output logic [crcsd_pkg::GEN_W-1:0]    generator_low,
  output logic [EDW-1:0]                 eff_degree,
  output logic                           check_mode
);
  import crcsd_pkg::*;

  logic [GEN_W-1:0]    generator_r;
  logic [DEGREE_W-1:0] degree_r;
  logic                check_mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      generator_r  <= GEN_RESET;
      degree_r     <= DEGREE_RESET;
      check_mode_r <= 1'b0;
    end else if (wr_en) begin
      case (cfg_reg_t'(wr_index))
        REG_GENERATOR_LOW: generator_r  <= wr_data;
        REG_DEGREE:        degree_r     <= wr_data[DEGREE_W-1:0];
        REG_CHECK_MODE:    check_mode_r <= wr_data[0];
        default: ;
      endcase
    end
  end

  // A degree of zero acts as one; anything above the built width is cut to it.
  always_comb begin
    if (degree_r == '0) begin
      eff_degree = EDW'(1);
    end else if (int'(degree_r) > MAX_DEGREE) begin
      eff_degree = EDW'(MAX_DEGREE);
    end else begin
      eff_degree = EDW'(degree_r);
    end
  end

  assign generator_low = generator_r;
  assign check_mode    = check_mode_r;

endmodule

/* design/crcsd_step.sv */
// One GF(2) long-division step of the serial CRC divider: quotient bit,
// next partial remainder and the result transaction. Depends on crcsd_pkg.
module crcsd_step #(
  parameter int MAX_DEGREE = crcsd_pkg::MAX_DEGREE_DEF,
  parameter int EDW        = $clog2(MAX_DEGREE + 1)
) (
  input  logic [MAX_DEGREE-1:0]       rem,
  input  crcsd_pkg::in_item_t         item,
  input  logic [crcsd_pkg::GEN_W-1:0] generator_low,
  input  logic [EDW-1:0]              eff_degree,
  input  logic                        check_mode,
  output logic [MAX_DEGREE-1:0]       rem_nxt,
  output crcsd_pkg::out_item_t        result
);
  import crcsd_pkg::*;

  localparam int IW = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
  localparam int XW = (MAX_DEGREE > GEN_W) ? MAX_DEGREE : GEN_W;

  logic [MAX_DEGREE-1:0] mask;
  logic [MAX_DEGREE-1:0] gen_w;
  logic [MAX_DEGREE-1:0] rem_m;
  logic [MAX_DEGREE-1:0] shifted;
  logic [MAX_DEGREE-1:0] rem_new;
  logic [XW-1:0]         gen_ext;
  logic [XW-1:0]         rem_ext;
  logic [EDW-1:0]        top_pos;
  logic [IW-1:0]         top_idx;
  logic                  top;
  logic                  q;

  always_comb begin
    for (int i = 0; i < MAX_DEGREE; i++) begin
      mask[i] = (i < int'(eff_degree));
    end
  end

  assign gen_ext = XW'(generator_low);
  assign gen_w   = gen_ext[MAX_DEGREE-1:0] & mask;
  assign rem_m   = rem & mask;
  assign top_pos = eff_degree - EDW'(1);
  assign top_idx = IW'(top_pos);
  assign top     = rem_m[top_idx];

  // In check mode the received bit enters the window; in encode mode it is
  // folded into the feedback, which stands for the appended zero padding.
  always_comb begin
    if (check_mode) begin
      q       = top;
      shifted = ((rem_m << 1) | MAX_DEGREE'(item.data_bit)) & mask;
    end else begin
      q       = top ^ item.data_bit;
      shifted = (rem_m << 1) & mask;
    end
    rem_new = q ? (shifted ^ gen_w) : shifted;
  end

  assign rem_ext = XW'(rem_new);

  always_comb begin
    result.quotient_bit = q;
    result.frame_end    = item.last;
    result.remainder    = item.last ? rem_ext[GEN_W-1:0] : '0;
    result.error        = item.last & (|rem_new);
  end

  assign rem_nxt = item.last ? '0 : rem_new;

endmodule
